// ===== hw/rtl/bdq_pkg.sv =====
// Shared operation codes and status codes for the bounded double-ended queue.
package bdq_pkg;

   // Operation codes carried on the request channel.
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [2:0] FUNC_READ       = 3'd4;

   // Status codes returned on the response channel.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   localparam int WORD_WIDTH = 32;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

endpackage

// ===== hw/rtl/bdq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bounded_double_ended_queue.sv =====
// Top level of the bounded double-ended queue with its pointer control.
//
//   Channel   Ports                                   Transfer
//   --------  --------------------------------------  ----------------------------
//   request   start, busy, req_func/data_in/index     start high while busy low
//   response  rsp_strobe, rsp_value, rsp_status       rsp_strobe high for one cycle
//
// A request is taken in any cycle; busy stays low, so one transfer per cycle is sustained.
// The response appears in the cycle after its request, from the registered read of the slot RAM.
// Pointers are updated at the request edge, so the next request sees the new queue at once.
// Synchronous reset empties the queue with both pointers on the middle slot; slots keep data.
// The receiver cannot stall: each response is valid for its single strobe cycle only.
module bounded_double_ended_queue #(
   parameter int DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_func,
   input  logic signed [31:0]  req_data_in,
   input  logic [4:0]          req_index,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_value,
   output logic [1:0]          rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = ((AW > 5) ? AW : 5) + 1;
   localparam logic [AW-1:0] MID_SLOT  = AW'(DEPTH / 2);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic            accept;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   tail_ff, tail_in;
   logic            empty_ff, empty_in;
   logic            rsp_strobe_ff;
   logic            use_ram_ff, use_ram_in;
   bdq_pkg::word_type fixed_value_ff, fixed_value_in;
   logic [1:0]      status_ff, status_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;
   logic [31:0]     rd_data;
   logic [CW-1:0]   span;
   logic [CW-1:0]   read_pos;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Span of the live words and the slot addressed by an indexed read.
   assign span     = CW'(tail_ff) - CW'(head_ff);
   assign read_pos = CW'(head_ff) + CW'(req_index);

   // Decode the request and work out the pointer update and the response.
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      wr_en          = 1'b0;
      wr_addr        = head_ff;
      rd_addr        = head_ff;
      use_ram_in     = 1'b0;
      fixed_value_in = '0;
      status_in      = bdq_pkg::STATUS_OK;
      unique case (req_func) inside
         bdq_pkg::FUNC_PUSH_FRONT, bdq_pkg::FUNC_PUSH_BACK: begin
            if (empty_ff) begin
               head_in  = MID_SLOT;
               tail_in  = MID_SLOT;
               empty_in = 1'b0;
               wr_en    = 1'b1;
               wr_addr  = MID_SLOT;
            end else if (req_func == bdq_pkg::FUNC_PUSH_FRONT) begin
               if (head_ff == '0) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  head_in = head_ff - AW'(1);
                  wr_en   = 1'b1;
                  wr_addr = head_ff - AW'(1);
               end
            end else begin
               if (tail_ff == LAST_SLOT) begin
                  status_in = bdq_pkg::STATUS_FULL;
               end else begin
                  tail_in = tail_ff + AW'(1);
                  wr_en   = 1'b1;
                  wr_addr = tail_ff + AW'(1);
               end
            end
         end
         bdq_pkg::FUNC_POP_FRONT, bdq_pkg::FUNC_POP_BACK: begin
            if (empty_ff) begin
               status_in = bdq_pkg::STATUS_EMPTY;
            end else begin
               use_ram_in = 1'b1;
               rd_addr    = (req_func == bdq_pkg::FUNC_POP_FRONT) ? head_ff : tail_ff;
               if (head_ff == tail_ff) begin
                  head_in  = MID_SLOT;
                  tail_in  = MID_SLOT;
                  empty_in = 1'b1;
               end else if (req_func == bdq_pkg::FUNC_POP_FRONT) begin
                  head_in = head_ff + AW'(1);
               end else begin
                  tail_in = tail_ff - AW'(1);
               end
            end
         end
         bdq_pkg::FUNC_READ: begin
            if (empty_ff || (CW'(req_index) > span)) begin
               status_in      = bdq_pkg::STATUS_RANGE;
               fixed_value_in = '1;
            end else begin
               use_ram_in = 1'b1;
               rd_addr    = read_pos[AW-1:0];
            end
         end
         default: begin
         end
      endcase
      wr_en = wr_en && accept;
   end

   // Queue pointers and the empty flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= MID_SLOT;
         tail_ff  <= MID_SLOT;
         empty_ff <= 1'b1;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   // Response register; the word comes from the RAM read register or the fixed value.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         use_ram_ff     <= use_ram_in;
         fixed_value_ff <= fixed_value_in;
         status_ff      <= status_in;
      end
   end

   // Slot store.
   bdq_ram #(
      .WIDTH (bdq_pkg::WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = use_ram_ff ? $signed(rd_data) : fixed_value_ff;
   assign rsp_status = status_ff;

   // The live words never run backwards through the store.
   assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (head_ff <= tail_ff))
      else $error("head pointer passed tail pointer");

   // An empty queue keeps both pointers on the middle slot.
   assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> ((head_ff == MID_SLOT) && (tail_ff == MID_SLOT)))
      else $error("empty queue with pointers off the middle slot");

   // Every transfer in gives exactly one response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response missing after request");

   assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without request");

   // A range error always returns all ones.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == bdq_pkg::STATUS_RANGE)) |-> (rsp_value == -32'sd1))
      else $error("range error with wrong value");

endmodule
